### rtl/buffer_pool_and_linked_queue_macros.svh
// Assertion macros for the buffer pool and linked queue block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BUFFER_POOL_AND_LINKED_QUEUE_MACROS_SVH
`define BUFFER_POOL_AND_LINKED_QUEUE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BPLQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: ante |-> cons");

// Next-cycle implication, disabled during reset.
`define BPLQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: ante |=> cons");

`endif

### rtl/bplq_pkg.sv
// Shared types and constants for the buffer pool and linked queue.
// No dependencies.
`timescale 1ns / 1ps

package bplq_pkg;

   localparam int IDX_W = 6;

   typedef enum logic [1:0] {
      OP_ALLOC = 2'd0,
      OP_FREE  = 2'd1,
      OP_ENQ   = 2'd2,
      OP_DEQ   = 2'd3
   } op_type;

   // Sequencing strobes from the controller to the list engine.
   typedef struct packed {
      logic start;
      logic commit;
   } eng_ctl_type;

   typedef struct packed {
      logic [IDX_W-1:0] result_index;
      logic             status;
   } rsp_word_type;

endpackage

### rtl/buffer_pool_and_linked_queue.sv
// Top level: sequencer, link RAM clearing pass and result register.
// Depends on bplq_pkg, bplq_ram, bplq_engine and the assertion macros.
//
//   channel | direction | ports
//   --------+-----------+----------------------------------------------
//   req     | in        | req_valid, req_ready, req_op, req_buffer_index
//   rsp     | out       | rsp_valid, rsp_ready, rsp_result_index, rsp_status
//
// The accept cycle reads the link RAM at the head that may be popped; the
// execute state then applies the update and writes back.
// After reset a clearing pass writes every link RAM entry with the initial
// free chain; req_ready stays low until it ends.
// A word accepted while a result is still held waits in the execute state
// until rsp_ready frees the result register.
`timescale 1ns / 1ps
`include "buffer_pool_and_linked_queue_macros.svh"

module buffer_pool_and_linked_queue
   import bplq_pkg::*;
#(
   parameter int NUM_BUFFERS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [IDX_W-1:0] req_buffer_index,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output logic [IDX_W-1:0] rsp_result_index,
   output logic             rsp_status
);

   localparam int LW = $clog2(NUM_BUFFERS + 1);
   localparam int AW = $clog2(NUM_BUFFERS);
   localparam logic [LW-1:0] LINK_NONE = LW'(NUM_BUFFERS);
   localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BUFFERS - 1);

   typedef enum logic [1:0] {
      S_INIT,
      S_IDLE,
      S_EXEC
   } state_type;

   state_type    state_ff;
   logic [AW-1:0] init_cnt_ff;
   logic         rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   eng_ctl_type  ctl;
   rsp_word_type rsp_word;
   logic [AW-1:0] eng_rd_addr, eng_wr_addr, ram_wr_addr;
   logic [LW-1:0] eng_wr_data, ram_wr_data, ram_rd_data;
   logic          eng_wr_en, ram_wr_en;

   assign req_ready  = (state_ff == S_IDLE);
   assign ctl.start  = req_valid && req_ready;
   assign ctl.commit = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_ready);

   // Clearing pass: entry i links to i-1, entry 0 ends the chain.
   always_comb begin
      if (state_ff == S_INIT) begin
         ram_wr_en   = 1'b1;
         ram_wr_addr = init_cnt_ff;
         ram_wr_data = (init_cnt_ff == '0) ? LINK_NONE : (LW'(init_cnt_ff) - 1'b1);
      end else begin
         ram_wr_en   = eng_wr_en;
         ram_wr_addr = eng_wr_addr;
         ram_wr_data = eng_wr_data;
      end
   end

   bplq_ram #(
      .WIDTH (LW),
      .DEPTH (NUM_BUFFERS)
   ) u_link_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ctl.start),
      .rd_addr (eng_rd_addr),
      .rd_data (ram_rd_data)
   );

   bplq_engine #(
      .NUM_BUFFERS (NUM_BUFFERS)
   ) u_engine (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .req_op           (req_op),
      .req_buffer_index (req_buffer_index),
      .rd_data          (ram_rd_data),
      .rd_addr          (eng_rd_addr),
      .wr_en            (eng_wr_en),
      .wr_addr          (eng_wr_addr),
      .wr_data          (eng_wr_data),
      .rsp_word         (rsp_word)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         init_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            S_INIT: begin
               init_cnt_ff <= init_cnt_ff + 1'b1;
               if (init_cnt_ff == LAST_ADDR) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (ctl.start) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (ctl.commit) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_INIT;
            end
         endcase
         // Hold the result until taken; load a fresh one on commit.
         if (ctl.commit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit) begin
         rsp_word_ff <= rsp_word;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_index = rsp_word_ff.result_index;
   assign rsp_status       = rsp_word_ff.status;

   `BPLQ_ASSERT_NEXT(a_start_to_exec, clock, reset, ctl.start, state_ff == S_EXEC)
   `BPLQ_ASSERT_NEXT(a_commit_gives_rsp, clock, reset, ctl.commit, rsp_valid_ff)
   `BPLQ_ASSERT_NOW(a_no_write_while_idle, clock, reset, state_ff == S_IDLE, !ram_wr_en)

endmodule

### rtl/bplq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bplq_ram #(
   parameter int WIDTH = 7,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/bplq_engine.sv
// List engine: free-list head, queue head and tail, and the per-op update.
// Depends on bplq_pkg; drives the link RAM ports through the top level.
`timescale 1ns / 1ps

module bplq_engine
   import bplq_pkg::*;
#(
   parameter int NUM_BUFFERS = 64
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  eng_ctl_type                            ctl,
   input  logic [1:0]                             req_op,
   input  logic [IDX_W-1:0]                       req_buffer_index,
   input  logic [$clog2(NUM_BUFFERS+1)-1:0]       rd_data,
   output logic [$clog2(NUM_BUFFERS)-1:0]         rd_addr,
   output logic                                   wr_en,
   output logic [$clog2(NUM_BUFFERS)-1:0]         wr_addr,
   output logic [$clog2(NUM_BUFFERS+1)-1:0]       wr_data,
   output rsp_word_type                           rsp_word
);

   localparam int LW = $clog2(NUM_BUFFERS + 1);
   localparam int AW = $clog2(NUM_BUFFERS);
   localparam int CW = (LW > IDX_W) ? LW : IDX_W;
   localparam logic [LW-1:0] LINK_NONE = LW'(NUM_BUFFERS);
   localparam logic [LW-1:0] LINK_TOP  = LW'(NUM_BUFFERS - 1);
   localparam logic [CW-1:0] NB_CW     = CW'(NUM_BUFFERS);

   function automatic logic is_buf(input logic [LW-1:0] v);
      return CW'(v) < NB_CW;
   endfunction

   op_type           op_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [LW-1:0]    free_head_ff, free_head_in;
   logic [LW-1:0]    queue_head_ff, queue_head_in;
   logic [LW-1:0]    queue_tail_ff, queue_tail_in;

   logic          idx_ok;
   logic [LW-1:0] idx_link;
   logic [LW-1:0] rd_sel;

   assign idx_ok   = CW'(idx_ff) < NB_CW;
   assign idx_link = LW'(idx_ff);

   // Read the link of whichever head the incoming word may pop.
   assign rd_sel  = (op_type'(req_op) == OP_DEQ) ? queue_head_ff : free_head_ff;
   assign rd_addr = is_buf(rd_sel) ? rd_sel[AW-1:0] : '0;

   always_comb begin
      free_head_in           = free_head_ff;
      queue_head_in          = queue_head_ff;
      queue_tail_in          = queue_tail_ff;
      wr_en                  = 1'b0;
      wr_addr                = '0;
      wr_data                = free_head_ff;
      rsp_word.result_index  = '0;
      rsp_word.status        = 1'b0;
      unique case (op_ff)
         OP_ALLOC: begin
            if (is_buf(free_head_ff)) begin
               rsp_word.result_index = IDX_W'(free_head_ff);
               free_head_in          = rd_data;
            end else begin
               rsp_word.status = 1'b1;
            end
         end
         OP_FREE: begin
            rsp_word.result_index = idx_ff;
            if (idx_ok) begin
               wr_en        = 1'b1;
               wr_addr      = AW'(idx_ff);
               wr_data      = free_head_ff;
               free_head_in = idx_link;
            end
         end
         OP_ENQ: begin
            rsp_word.result_index = idx_ff;
            if (idx_ok) begin
               if (!is_buf(queue_head_ff)) begin
                  queue_head_in = idx_link;
               end else if (is_buf(queue_tail_ff)) begin
                  wr_en   = 1'b1;
                  wr_addr = queue_tail_ff[AW-1:0];
                  wr_data = idx_link;
               end
               queue_tail_in = idx_link;
            end
         end
         OP_DEQ: begin
            if (!is_buf(queue_head_ff)) begin
               rsp_word.status = 1'b1;
            end else begin
               rsp_word.result_index = IDX_W'(queue_head_ff);
               if (queue_head_ff == queue_tail_ff) begin
                  queue_head_in = LINK_NONE;
                  queue_tail_in = LINK_NONE;
               end else begin
                  queue_head_in = rd_data;
               end
            end
         end
         default: begin
         end
      endcase
      if (!ctl.commit) begin
         wr_en = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.start) begin
         op_ff  <= op_type'(req_op);
         idx_ff <= req_buffer_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         free_head_ff  <= LINK_TOP;
         queue_head_ff <= LINK_NONE;
         queue_tail_ff <= LINK_NONE;
      end else if (ctl.commit) begin
         free_head_ff  <= free_head_in;
         queue_head_ff <= queue_head_in;
         queue_tail_ff <= queue_tail_in;
      end
   end

endmodule

### tb/bplq_checker.sv
// Checker for the buffer pool and linked queue: tracks the link store, free list
// and queue from accepted request words and compares every result word in order.
// Depends on bplq_pkg.
`timescale 1ns / 1ps

module bplq_checker
   import bplq_pkg::*;
#(
   parameter int NUM_BUFFERS = 64
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  logic [1:0]       req_op,
   input  logic [IDX_W-1:0] req_buffer_index,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  logic [IDX_W-1:0] rsp_result_index,
   input  logic             rsp_status,
   output int               fail_count,
   output int               pending
);

   localparam int LINK_W = $clog2(NUM_BUFFERS + 1);
   localparam int ADDR_W = $clog2(NUM_BUFFERS);

   typedef logic [LINK_W-1:0] link_type;

   localparam link_type LINK_NONE = link_type'(NUM_BUFFERS);

   link_type     next_buf [NUM_BUFFERS];
   link_type     pool_head;
   link_type     fifo_head;
   link_type     fifo_tail;
   rsp_word_type expected_rsp [$];
   int           words_checked;

   initial begin
      fail_count = 0;
      pending = 0;
      words_checked = 0;
   end

   task automatic report_mismatch(string what);
      fail_count++;
      $display("%0t ns: result word %0d: %s", $time, words_checked, what);
   endtask

   // Apply one operation to the tracked lists and return the result word it yields.
   function automatic rsp_word_type apply_buffer_op(op_type op, logic [IDX_W-1:0] idx);
      rsp_word_type r;
      link_type     b;
      b = link_type'(idx);
      r.result_index = '0;
      r.status = 1'b0;
      case (op)
         OP_ALLOC: begin
            if (pool_head < NUM_BUFFERS) begin
               r.result_index = pool_head[IDX_W-1:0];
               pool_head = next_buf[pool_head[ADDR_W-1:0]];
            end else begin
               r.status = 1'b1;
            end
         end
         OP_FREE: begin
            r.result_index = idx;
            if (b < NUM_BUFFERS) begin
               next_buf[b[ADDR_W-1:0]] = pool_head;
               pool_head = b;
            end
         end
         OP_ENQ: begin
            r.result_index = idx;
            if (b < NUM_BUFFERS) begin
               // an empty queue restarts at this buffer and leaves its link alone
               if (!(fifo_head < NUM_BUFFERS)) begin
                  fifo_head = b;
                  fifo_tail = b;
               end else begin
                  if (fifo_tail < NUM_BUFFERS)
                     next_buf[fifo_tail[ADDR_W-1:0]] = b;
                  fifo_tail = b;
               end
            end
         end
         default: begin
            if (!(fifo_head < NUM_BUFFERS)) begin
               r.status = 1'b1;
            end else if (fifo_head == fifo_tail) begin
               r.result_index = fifo_head[IDX_W-1:0];
               fifo_head = LINK_NONE;
               fifo_tail = LINK_NONE;
            end else begin
               r.result_index = fifo_head[IDX_W-1:0];
               fifo_head = next_buf[fifo_head[ADDR_W-1:0]];
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_word_type want;
      rsp_word_type got;
      if (reset) begin
         next_buf[0] = LINK_NONE;
         for (int i = 1; i < NUM_BUFFERS; i++)
            next_buf[i[ADDR_W-1:0]] = link_type'(i - 1);
         pool_head = link_type'(NUM_BUFFERS - 1);
         fifo_head = LINK_NONE;
         fifo_tail = LINK_NONE;
         expected_rsp.delete();
      end else begin
         // compare first: a result word can never come from the same edge's request
         if (rsp_valid && rsp_ready) begin
            got.result_index = rsp_result_index;
            got.status = rsp_status;
            if (expected_rsp.size() == 0) begin
               report_mismatch($sformatf("unexpected word index %0d status %0b",
                  got.result_index, got.status));
            end else begin
               want = expected_rsp.pop_front();
               if (got.result_index !== want.result_index)
                  report_mismatch($sformatf("result_index %0d, want %0d",
                     got.result_index, want.result_index));
               if (got.status !== want.status)
                  report_mismatch($sformatf("status %0b, want %0b",
                     got.status, want.status));
            end
            words_checked++;
         end
         if (req_valid && req_ready)
            expected_rsp.push_back(apply_buffer_op(op_type'(req_op), req_buffer_index));
      end
      pending <= expected_rsp.size();
   end

endmodule

### tb/tb_buffer_pool_and_linked_queue.sv
// Testbench top for the buffer pool and linked queue: drives request words with
// random gaps, stalls the result side, and gives the verdict from bplq_checker.
// Depends on bplq_pkg, bplq_checker and the block itself.
`timescale 1ns / 1ps

module tb_buffer_pool_and_linked_queue;
   import bplq_pkg::*;

   localparam int NUM_BUFS = 64;
   localparam int MAX_GAP = 18;
   localparam int LONG_HOLD = 400;
   localparam int HOLD_AT_WORD = 300;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   logic [1:0]       req_op;
   logic [IDX_W-1:0] req_buffer_index;
   logic             rsp_valid;
   logic             rsp_ready;
   logic [IDX_W-1:0] rsp_result_index;
   logic             rsp_status;
   int               fail_count;
   int               pending;

   // Buffer ownership as seen by the sender, valid only while use is well formed.
   int pool_stack [$];
   int owned [$];
   int in_queue [$];
   bit tracking_ok = 1'b1;
   bit req_steady = 1'b0;
   bit rsp_steady = 1'b0;
   bit long_hold = 1'b0;
   int words_sent = 0;

   buffer_pool_and_linked_queue #(
      .NUM_BUFFERS(NUM_BUFS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_buffer_index(req_buffer_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_index(rsp_result_index),
      .rsp_status(rsp_status)
   );

   bplq_checker #(
      .NUM_BUFFERS(NUM_BUFS)
   ) i_checker (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_op(req_op),
      .req_buffer_index(req_buffer_index),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_result_index(rsp_result_index),
      .rsp_status(rsp_status),
      .fail_count(fail_count),
      .pending(pending)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("TEST FAILED");
      $finish;
   end

   function automatic logic [IDX_W-1:0] rand_index();
      return IDX_W'($urandom_range(0, NUM_BUFS - 1));
   endfunction

   function automatic void release_owned(int idx);
      for (int i = 0; i < owned.size(); i++) begin
         if (owned[i] == idx) begin
            owned.delete(i);
            break;
         end
      end
   endfunction

   // Offer one word after a random gap and hold it until accepted.
   task automatic send_word(op_type op, logic [IDX_W-1:0] idx);
      int gap;
      gap = req_steady ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op <= op;
      req_buffer_index <= idx;
      do @(posedge clock); while (!req_ready);
      if (tracking_ok) begin
         case (op)
            OP_ALLOC: if (pool_stack.size() > 0) owned.push_back(pool_stack.pop_back());
            OP_FREE: begin
               release_owned(idx);
               pool_stack.push_back(idx);
            end
            OP_ENQ: begin
               release_owned(idx);
               in_queue.push_back(idx);
            end
            default: if (in_queue.size() > 0) owned.push_back(in_queue.pop_front());
         endcase
      end
      words_sent++;
      if (words_sent == HOLD_AT_WORD)
         long_hold <= 1'b1;
      if ($urandom_range(0, 39) == 0)
         req_steady = !req_steady;
   endtask

   // Drop valid and wait until every result word is back.
   task automatic drain_results();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
   endtask

   // Proper use with a drifting balance between taking and returning buffers.
   task automatic run_wellformed(int count);
      int fill_pct;
      int pick;
      int k;
      fill_pct = 50;
      repeat (count) begin
         if ($urandom_range(0, 29) == 0)
            fill_pct = $urandom_range(5, 95);
         pick = $urandom_range(0, 99);
         if (owned.size() == 0) begin
            send_word(pick < 50 ? OP_ALLOC : OP_DEQ, rand_index());
         end else if (pick < fill_pct / 2) begin
            send_word(OP_ALLOC, rand_index());
         end else if (pick < fill_pct) begin
            send_word(OP_DEQ, rand_index());
         end else begin
            k = $urandom_range(0, owned.size() - 1);
            send_word($urandom_range(0, 1) ? OP_FREE : OP_ENQ, IDX_W'(owned[k]));
         end
      end
   endtask

   // Result side: random stalls, calm stretches, and one long hold-off.
   initial begin
      int stall;
      rsp_ready = 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         if (long_hold) begin
            stall = LONG_HOLD;
            long_hold <= 1'b0;
         end else begin
            stall = rsp_steady ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         if ($urandom_range(0, 39) == 0)
            rsp_steady = !rsp_steady;
      end
   end

   initial begin
      int a;
      int b;
      int c;
      reset = 1'b1;
      req_valid = 1'b0;
      req_op = OP_ALLOC;
      req_buffer_index = '0;
      for (int i = 0; i < NUM_BUFS; i++)
         pool_stack.push_back(i);
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // dequeue an empty queue, then a short queue down to its last element
      send_word(OP_DEQ, 6'd63);
      send_word(OP_DEQ, 6'd0);
      send_word(OP_ALLOC, 6'd0);
      send_word(OP_ALLOC, 6'd63);
      send_word(OP_ENQ, 6'd63);
      send_word(OP_ENQ, 6'd62);
      send_word(OP_ALLOC, 6'd42);
      send_word(OP_ENQ, 6'd61);
      send_word(OP_DEQ, 6'd21);
      send_word(OP_DEQ, 6'd0);
      send_word(OP_DEQ, 6'd63);
      send_word(OP_DEQ, 6'd63);
      send_word(OP_FREE, 6'd61);
      send_word(OP_FREE, 6'd63);
      send_word(OP_FREE, 6'd62);
      send_word(OP_ALLOC, 6'd0);
      send_word(OP_ENQ, 6'd62);
      send_word(OP_DEQ, 6'd0);
      send_word(OP_FREE, 6'd62);
      drain_results();

      run_wellformed(350);
      drain_results();
      run_wellformed(350);

      // empty the queue and the pool, then starve a queue link
      while (in_queue.size() > 0)
         send_word(OP_DEQ, rand_index());
      while (pool_stack.size() > 0)
         send_word(OP_ALLOC, rand_index());
      send_word(OP_ALLOC, rand_index());
      a = owned[0];
      b = owned[1];
      c = owned[2];
      tracking_ok = 1'b0;
      send_word(OP_ENQ, IDX_W'(a));
      send_word(OP_ENQ, IDX_W'(b));
      // free list is empty, so the queue head now links to none
      send_word(OP_FREE, IDX_W'(a));
      send_word(OP_DEQ, rand_index());
      send_word(OP_DEQ, rand_index());
      send_word(OP_ENQ, IDX_W'(c));
      send_word(OP_DEQ, rand_index());
      drain_results();

      // misuse: double frees, stray enqueues, anything goes
      repeat (120)
         send_word(op_type'($urandom_range(0, 3)), rand_index());
      drain_results();
      repeat (20) @(posedge clock);

      if (fail_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

### filelist.f
+incdir+rtl
rtl/bplq_pkg.sv
rtl/bplq_ram.sv
rtl/bplq_engine.sv
rtl/buffer_pool_and_linked_queue.sv
tb/bplq_checker.sv
tb/tb_buffer_pool_and_linked_queue.sv
